// File: rtl/cfi_pkg.sv
// Shared types, codes and constants for the frame intrusion filter.
`timescale 1ns / 1ps

package cfi_pkg;

    localparam int GROUP_W    = 18;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int STAMP_W    = 32;
    localparam int REASON_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 8;

    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BURST_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHASSIS_SRC  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HMI_SRC      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_SRC     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_MAX      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FUEL_MAX     = 3'd7;

    // register reset values
    localparam logic [WORD_W-1:0] RST_BURST_WINDOW = 16'd5;
    localparam logic [BYTE_W-1:0] RST_BURST_LIMIT  = 8'd20;
    localparam logic [BYTE_W-1:0] RST_CHASSIS_SRC  = 8'd17;
    localparam logic [BYTE_W-1:0] RST_HMI_SRC      = 8'd33;
    localparam logic [BYTE_W-1:0] RST_FIRE_SRC     = 8'd97;
    localparam logic [WORD_W-1:0] RST_SPEED_MAX    = 16'd38400;
    localparam logic [WORD_W-1:0] RST_RPM_MAX      = 16'd32000;
    localparam logic [WORD_W-1:0] RST_FUEL_MAX     = 16'd4000;

    // whitelisted group numbers
    localparam logic [GROUP_W-1:0] GRP_SPEED = 18'h0FEF1;
    localparam logic [GROUP_W-1:0] GRP_RPM   = 18'h0F004;
    localparam logic [GROUP_W-1:0] GRP_FUEL  = 18'h0FEE9;
    localparam logic [GROUP_W-1:0] GRP_PTO   = 18'h0E100;
    localparam logic [GROUP_W-1:0] GRP_PUMP  = 18'h0E200;
    localparam logic [GROUP_W-1:0] GRP_MAST  = 18'h0E300;
    localparam logic [GROUP_W-1:0] GRP_PRES  = 18'h0D100;
    localparam logic [GROUP_W-1:0] GRP_WATER = 18'h0D200;
    localparam logic [GROUP_W-1:0] GRP_FOAM  = 18'h0D300;

    // verdict reason codes
    localparam logic [REASON_W-1:0] RSN_OK        = 4'd0;
    localparam logic [REASON_W-1:0] RSN_BURST     = 4'd1;
    localparam logic [REASON_W-1:0] RSN_BARRED    = 4'd2;
    localparam logic [REASON_W-1:0] RSN_CHASSIS   = 4'd3;
    localparam logic [REASON_W-1:0] RSN_HMI       = 4'd4;
    localparam logic [REASON_W-1:0] RSN_FIRE      = 4'd5;
    localparam logic [REASON_W-1:0] RSN_SPEED     = 4'd6;
    localparam logic [REASON_W-1:0] RSN_RPM       = 4'd7;
    localparam logic [REASON_W-1:0] RSN_FUEL      = 4'd8;

    typedef enum logic [2:0] {
        CLS_BARRED = 3'd0,
        CLS_SPEED  = 3'd1,
        CLS_RPM    = 3'd2,
        CLS_FUEL   = 3'd3,
        CLS_HMI    = 3'd4,
        CLS_FIRE   = 3'd5
    } t_class;

    // classified item handed from front to back
    typedef struct packed {
        logic               burst;
        t_class             grp_class;
        logic [BYTE_W-1:0]  src;
        logic [WORD_W-1:0]  word;
    } t_job;

    // configuration seen by the back end
    typedef struct packed {
        logic [BYTE_W-1:0] chassis_src;
        logic [BYTE_W-1:0] hmi_src;
        logic [BYTE_W-1:0] fire_src;
        logic [WORD_W-1:0] speed_max;
        logic [WORD_W-1:0] rpm_max;
        logic [WORD_W-1:0] fuel_max;
    } t_chk_cfg;

endpackage

// File: rtl/cfi_front.sv
// Front end: burst tracking and group classification of each incoming frame.
`timescale 1ns / 1ps

module cfi_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [cfi_pkg::GROUP_W-1:0]   i_group_number,
    input  logic [cfi_pkg::BYTE_W-1:0]    i_source_addr,
    input  logic [cfi_pkg::BYTE_W-1:0]    i_byte_zero,
    input  logic [cfi_pkg::BYTE_W-1:0]    i_byte_one,
    input  logic [cfi_pkg::STAMP_W-1:0]   i_stamp_ms,
    input  logic [cfi_pkg::WORD_W-1:0]    i_burst_window,
    input  logic [cfi_pkg::BYTE_W-1:0]    i_burst_limit,
    output cfi_pkg::t_job                 o_job
);

    logic [cfi_pkg::STAMP_W-1:0] r_prev_stamp, n_prev_stamp;
    logic [cfi_pkg::GROUP_W-1:0] r_prev_group, n_prev_group;
    logic [cfi_pkg::COUNT_W-1:0] r_count, n_count;

    logic [cfi_pkg::STAMP_W-1:0] gap;
    logic [cfi_pkg::COUNT_W-1:0] count_inc;
    logic                        repeat_hit;
    logic                        burst;
    cfi_pkg::t_class             grp_class;

    assign gap        = i_stamp_ms - r_prev_stamp;
    // gap is below a 16-bit window only if its upper half is clear
    assign repeat_hit = (i_group_number == r_prev_group)
                        && (gap[cfi_pkg::STAMP_W-1:cfi_pkg::WORD_W] == '0)
                        && (gap[cfi_pkg::WORD_W-1:0] < i_burst_window);
    assign count_inc  = (r_count == '1) ? r_count : r_count + 1'b1;
    assign burst      = repeat_hit && (count_inc > i_burst_limit);

    always_comb begin
        n_count      = repeat_hit ? count_inc : '0;
        n_prev_stamp = burst ? r_prev_stamp : i_stamp_ms;
        n_prev_group = burst ? r_prev_group : i_group_number;
    end

    always_comb begin
        unique case (i_group_number)
            cfi_pkg::GRP_SPEED: grp_class = cfi_pkg::CLS_SPEED;
            cfi_pkg::GRP_RPM:   grp_class = cfi_pkg::CLS_RPM;
            cfi_pkg::GRP_FUEL:  grp_class = cfi_pkg::CLS_FUEL;
            cfi_pkg::GRP_PTO,
            cfi_pkg::GRP_PUMP,
            cfi_pkg::GRP_MAST:  grp_class = cfi_pkg::CLS_HMI;
            cfi_pkg::GRP_PRES,
            cfi_pkg::GRP_WATER,
            cfi_pkg::GRP_FOAM:  grp_class = cfi_pkg::CLS_FIRE;
            default:            grp_class = cfi_pkg::CLS_BARRED;
        endcase
    end

    always_comb begin
        o_job.burst     = burst;
        o_job.grp_class = grp_class;
        o_job.src       = i_source_addr;
        o_job.word      = {i_byte_one, i_byte_zero};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_stamp <= '0;
            r_prev_group <= '0;
            r_count      <= '0;
        end else if (i_take) begin
            r_prev_stamp <= n_prev_stamp;
            r_prev_group <= n_prev_group;
            r_count      <= n_count;
        end
    end

endmodule

// File: rtl/cfi_queue.sv
// Short FIFO of classified items between front and back end.
`timescale 1ns / 1ps

module cfi_queue #(
    parameter int DEPTH = cfi_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  cfi_pkg::t_job i_wr_job,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_valid,
    output cfi_pkg::t_job o_rd_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cfi_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_fill, n_fill;
    logic          do_wr, do_rd;

    assign o_full   = (r_fill == CW'(DEPTH));
    assign o_valid  = (r_fill != '0);
    assign o_rd_job = r_mem[r_rd_ptr];
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   n_fill = r_fill + 1'b1;
            2'b01:   n_fill = r_fill - 1'b1;
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

// File: rtl/cfi_back.sv
// Back end: burst, whitelist, source and range checks, verdict held in the result register.
`timescale 1ns / 1ps

module cfi_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  cfi_pkg::t_job                 i_job,
    output logic                          o_job_take,
    input  cfi_pkg::t_chk_cfg             i_cfg,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_accept,
    output logic [cfi_pkg::REASON_W-1:0]  o_reason
);

    logic                          r_out_valid;
    logic [cfi_pkg::REASON_W-1:0]  r_reason, n_reason;

    // result register refills whenever it is free or being popped
    assign o_job_take = i_job_valid && (!r_out_valid || i_pop);
    assign o_empty    = !r_out_valid;
    assign o_reason   = r_reason;
    assign o_accept   = (r_reason == cfi_pkg::RSN_OK);

    always_comb begin
        n_reason = cfi_pkg::RSN_OK;
        if (i_job.burst) begin
            n_reason = cfi_pkg::RSN_BURST;
        end else begin
            case (i_job.grp_class)
                cfi_pkg::CLS_SPEED: begin
                    if (i_job.src != i_cfg.chassis_src) n_reason = cfi_pkg::RSN_CHASSIS;
                    else if (i_job.word > i_cfg.speed_max) n_reason = cfi_pkg::RSN_SPEED;
                end
                cfi_pkg::CLS_RPM: begin
                    if (i_job.src != i_cfg.chassis_src) n_reason = cfi_pkg::RSN_CHASSIS;
                    else if (i_job.word > i_cfg.rpm_max) n_reason = cfi_pkg::RSN_RPM;
                end
                cfi_pkg::CLS_FUEL: begin
                    if (i_job.src != i_cfg.chassis_src) n_reason = cfi_pkg::RSN_CHASSIS;
                    else if (i_job.word > i_cfg.fuel_max) n_reason = cfi_pkg::RSN_FUEL;
                end
                cfi_pkg::CLS_HMI: begin
                    if (i_job.src != i_cfg.hmi_src) n_reason = cfi_pkg::RSN_HMI;
                end
                cfi_pkg::CLS_FIRE: begin
                    if (i_job.src != i_cfg.fire_src) n_reason = cfi_pkg::RSN_FIRE;
                end
                default: n_reason = cfi_pkg::RSN_BARRED;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_reason <= n_reason;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_job_take) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// File: rtl/can_frame_intrusion_filter.sv
// Top level of the frame intrusion filter: config registers, front, queue, back.
// Flow: the front writes each accepted frame into the queue, and the back loads its
// verdict into the result register when that register is free or being popped.
// Throughput: one frame per cycle while the queue is not full.
// Reset: registers return to their defaults, burst state clears, queue and result register empty.
`timescale 1ns / 1ps

module can_frame_intrusion_filter #(
    parameter int QUEUE_DEPTH = cfi_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [cfi_pkg::GROUP_W-1:0]     i_group_number,
    input  logic [cfi_pkg::BYTE_W-1:0]      i_source_addr,
    input  logic [cfi_pkg::BYTE_W-1:0]      i_byte_zero,
    input  logic [cfi_pkg::BYTE_W-1:0]      i_byte_one,
    input  logic [cfi_pkg::STAMP_W-1:0]     i_stamp_ms,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_accept,
    output logic [cfi_pkg::REASON_W-1:0]    o_reason,
    input  logic                            i_cfg_we,
    input  logic [cfi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cfi_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [cfi_pkg::WORD_W-1:0] r_burst_window;
    logic [cfi_pkg::BYTE_W-1:0] r_burst_limit;
    cfi_pkg::t_chk_cfg          r_chk_cfg;

    cfi_pkg::t_job front_job, queue_job;
    logic          front_take;
    logic          queue_full, queue_valid, back_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_window        <= cfi_pkg::RST_BURST_WINDOW;
            r_burst_limit         <= cfi_pkg::RST_BURST_LIMIT;
            r_chk_cfg.chassis_src <= cfi_pkg::RST_CHASSIS_SRC;
            r_chk_cfg.hmi_src     <= cfi_pkg::RST_HMI_SRC;
            r_chk_cfg.fire_src    <= cfi_pkg::RST_FIRE_SRC;
            r_chk_cfg.speed_max   <= cfi_pkg::RST_SPEED_MAX;
            r_chk_cfg.rpm_max     <= cfi_pkg::RST_RPM_MAX;
            r_chk_cfg.fuel_max    <= cfi_pkg::RST_FUEL_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cfi_pkg::REG_BURST_WINDOW: r_burst_window <= i_cfg_data;
                cfi_pkg::REG_BURST_LIMIT:  r_burst_limit <= i_cfg_data[cfi_pkg::BYTE_W-1:0];
                cfi_pkg::REG_CHASSIS_SRC:
                    r_chk_cfg.chassis_src <= i_cfg_data[cfi_pkg::BYTE_W-1:0];
                cfi_pkg::REG_HMI_SRC:
                    r_chk_cfg.hmi_src <= i_cfg_data[cfi_pkg::BYTE_W-1:0];
                cfi_pkg::REG_FIRE_SRC:
                    r_chk_cfg.fire_src <= i_cfg_data[cfi_pkg::BYTE_W-1:0];
                cfi_pkg::REG_SPEED_MAX:    r_chk_cfg.speed_max <= i_cfg_data;
                cfi_pkg::REG_RPM_MAX:      r_chk_cfg.rpm_max <= i_cfg_data;
                cfi_pkg::REG_FUEL_MAX:     r_chk_cfg.fuel_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign full       = queue_full;
    assign front_take = push && !queue_full;

    cfi_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (front_take),
        .i_group_number (i_group_number),
        .i_source_addr  (i_source_addr),
        .i_byte_zero    (i_byte_zero),
        .i_byte_one     (i_byte_one),
        .i_stamp_ms     (i_stamp_ms),
        .i_burst_window (r_burst_window),
        .i_burst_limit  (r_burst_limit),
        .o_job          (front_job)
    );

    cfi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (front_take),
        .i_wr_job (front_job),
        .o_full   (queue_full),
        .i_rd     (back_take),
        .o_valid  (queue_valid),
        .o_rd_job (queue_job)
    );

    cfi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_job_take  (back_take),
        .i_cfg       (r_chk_cfg),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_accept    (o_accept),
        .o_reason    (o_reason)
    );

endmodule
